>>> src/lkvc_pkg.sv
package lkvc_pkg;

  // store geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int AGE_W   = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  // capacity register reset value
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(ENTRIES);

  // operation codes carried on the input tuser
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic do_compare;
    logic do_update;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic item_get;
    logic out_free;
  } stat_t;

endpackage

>>> src/lkvc_ctrl.sv
module lkvc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  lkvc_pkg::stat_t stat,
  output lkvc_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   upd_go;

  // an update for a get waits until the output register can take the result
  assign upd_go = !stat.item_get || stat.out_free;

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd.load_item  = 1'b0;
    cmd.do_compare = 1'b0;
    cmd.do_update  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.do_compare = 1'b1;
        state_next     = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          cmd.do_update = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/lkvc_datapath.sv
module lkvc_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  lkvc_pkg::cmd_t                     cmd,
  output lkvc_pkg::stat_t                    stat,
  input  logic                               cfg_we,
  input  logic [lkvc_pkg::CNT_W-1:0]         cfg_data,
  input  logic                               in_op,
  input  logic [lkvc_pkg::KEY_W-1:0]         in_key,
  input  logic [lkvc_pkg::VAL_W-1:0]         in_val,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic                               out_found,
  output logic [lkvc_pkg::VAL_W-1:0]         out_value
);

  // entry storage
  logic                         entry_valid [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::KEY_W-1:0]   entry_key   [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0]   entry_value [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::AGE_W-1:0]   entry_age   [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::CNT_W-1:0]   occupancy;
  logic [lkvc_pkg::CNT_W-1:0]   cap_limit;

  // latched item
  lkvc_pkg::op_t                item_op;
  logic [lkvc_pkg::KEY_W-1:0]   item_key;
  logic [lkvc_pkg::VAL_W-1:0]   item_val;

  // registered lookup results
  logic                         hit;
  logic [lkvc_pkg::IDX_W-1:0]   hit_idx;
  logic [lkvc_pkg::IDX_W-1:0]   victim_idx;
  logic                         is_full;

  // lookup logic
  logic                         match_any;
  logic [lkvc_pkg::IDX_W-1:0]   match_idx;
  logic [lkvc_pkg::IDX_W-1:0]   free_idx;
  logic [lkvc_pkg::IDX_W-1:0]   lru_idx;
  logic [lkvc_pkg::AGE_W-1:0]   lru_age;
  logic                         full_now;
  logic [lkvc_pkg::AGE_W-1:0]   hit_age;
  logic [lkvc_pkg::CNT_W-1:0]   cap_clamped;

  assign stat.item_get = (item_op == lkvc_pkg::OP_GET);
  assign stat.out_free = !m_tvalid || m_tready;

  // capacity clamp: zero acts as one, above the store size acts as full size
  always_comb begin
    if (cfg_data == '0) begin
      cap_clamped = lkvc_pkg::CNT_W'(1);
    end else if (cfg_data > lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES)) begin
      cap_clamped = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
    end else begin
      cap_clamped = cfg_data;
    end
  end

  // parallel key compare, first free slot and least recent slot
  assign lru_age  = lkvc_pkg::AGE_W'(occupancy - lkvc_pkg::CNT_W'(1));
  assign full_now = (occupancy >= cap_limit);

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    lru_idx   = '0;
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_key[i] == item_key) begin
        match_any = 1'b1;
        match_idx = lkvc_pkg::IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = lkvc_pkg::IDX_W'(i);
      end
      if (entry_valid[i] && entry_age[i] == lru_age) begin
        lru_idx = lkvc_pkg::IDX_W'(i);
      end
    end
  end

  assign hit_age = entry_age[hit_idx];

  // item and lookup result registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op  <= lkvc_pkg::op_t'(in_op);
      item_key <= in_key;
      item_val <= in_val;
    end
    if (cmd.do_compare) begin
      hit        <= match_any;
      hit_idx    <= match_idx;
      victim_idx <= full_now ? lru_idx : free_idx;
      is_full    <= full_now;
    end
  end

  // key and value storage, written on insert or put hit
  always_ff @(posedge clk) begin
    if (cmd.do_update && item_op == lkvc_pkg::OP_PUT) begin
      if (hit) begin
        entry_value[hit_idx] <= item_val;
      end else begin
        entry_key[victim_idx]   <= item_key;
        entry_value[victim_idx] <= item_val;
      end
    end
  end

  // valid bits, ages, occupancy and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
        entry_age[i]   <= '0;
      end
      occupancy <= '0;
      cap_limit <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      // a capacity write flushes the store
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
      occupancy <= '0;
      cap_limit <= cap_clamped;
    end else if (cmd.do_update) begin
      if (hit) begin
        // touch: younger entries age by one
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (entry_valid[i] && lkvc_pkg::IDX_W'(i) != hit_idx && entry_age[i] < hit_age) begin
            entry_age[i] <= entry_age[i] + lkvc_pkg::AGE_W'(1);
          end
        end
        entry_age[hit_idx] <= '0;
      end else if (item_op == lkvc_pkg::OP_PUT) begin
        // insert: all others age, new entry is most recent
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (entry_valid[i] && lkvc_pkg::IDX_W'(i) != victim_idx) begin
            entry_age[i] <= entry_age[i] + lkvc_pkg::AGE_W'(1);
          end
        end
        entry_valid[victim_idx] <= 1'b1;
        entry_age[victim_idx]   <= '0;
        if (!is_full) begin
          occupancy <= occupancy + lkvc_pkg::CNT_W'(1);
        end
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.do_update && item_op == lkvc_pkg::OP_GET) begin
      out_found <= hit;
      out_value <= hit ? entry_value[hit_idx] : '1;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.do_update && item_op == lkvc_pkg::OP_GET) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

>>> src/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement over
// 16 entries, of which the capacity register (reset 16; 0 acts as 1, values
// above 16 act as 16) sets how many are used before eviction begins. An input
// item is a get (tuser 0) or a put (tuser 1) with a 32-bit key and value in
// tdata. A get returns one item: tuser is 1 on a hit with the stored value in
// tdata, 0 on a miss with tdata all ones; a put returns nothing. Each item
// is taken only while the controller is idle, so a new item waits until the
// last has finished: the accepting state latches it, a compare state does the
// parallel key compare and victim selection over all entries, and an update
// state updates ages and storage; a get's update also waits until the output
// register is free, and its result is registered there by that update.
// Writing the capacity register empties the cache.
module lru_key_value_cache (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lkvc_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,   // lookup_key, store_value
  input  logic                        s_tuser,   // opcode
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // read_value
  output logic                        m_tuser    // found
);

  lkvc_pkg::cmd_t  cmd;
  lkvc_pkg::stat_t stat;

  // sequencer
  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry store and lookup
  lkvc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_op     (s_tuser),
    .in_key    (s_tdata[31:0]),
    .in_val    (s_tdata[63:32]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_found (m_tuser),
    .out_value (m_tdata)
  );

endmodule
